FILE: design/tfsl_pkg.sv
// Package for the timed frame sequence lookup block.
// Holds the table geometry, transaction structs, operation and direction codes.
// No dependencies.
package tfsl_pkg;

    localparam int MAX_FRAMES    = 256;
    localparam int DURATION_BITS = 16;
    localparam int FRAME_BITS    = $clog2(MAX_FRAMES);
    localparam int FIELD_BITS    = 8;
    localparam int TIME_BITS     = 32;
    localparam int TOTAL_BITS    = DURATION_BITS + FIELD_BITS + 1;
    localparam int STEP_BITS     = $clog2(TIME_BITS);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] DIR_FORWARD  = 2'd0;
    localparam logic [1:0] DIR_REVERSE  = 2'd1;
    localparam logic [1:0] DIR_PINGPONG = 2'd2;

    typedef struct packed {
        logic                  operation;
        logic [FIELD_BITS-1:0] table_index;
        logic [15:0]           frame_duration;
        logic [FIELD_BITS-1:0] first_frame;
        logic [FIELD_BITS-1:0] last_frame;
        logic [1:0]            play_direction;
        logic [TIME_BITS-1:0]  query_time;
    } tfsl_in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] frame_number;
        logic                  zero_length;
    } tfsl_out_t;

endpackage

FILE: design/tfsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tfsl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/timed_frame_sequence_lookup.sv
// Top level of the timed frame sequence lookup block: sequencer, serial
// remainder unit and frame walker. Depends on tfsl_pkg and tfsl_ram.
//
//  channel  | handshake                   | payload                | carries
//  ---------+-----------------------------+------------------------+---------------------
//  item     | item_valid / item_ready     | item   (tfsl_in_t)     | load or query
//  result   | result_valid / result_ready | result (tfsl_out_t)    | one per query
//
// A load is written to the table as it is accepted and the block stays ready. A query
// sums the range through the table's read port, computes the remainder bit-serially,
// then walks the frames in play order. The single table read port sets the pace of
// both walks.
// Reset clears only control state; the duration table holds garbage until loaded.
// A finished result waits in the output register while the next item is taken.
module timed_frame_sequence_lookup (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  tfsl_pkg::tfsl_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output tfsl_pkg::tfsl_out_t result
);

    import tfsl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_FIX   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_WALK  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]               state_reg, state_next;
    logic [FIELD_BITS-1:0]    first_reg, first_next;
    logic [FIELD_BITS-1:0]    last_reg, last_next;
    logic [1:0]               dir_reg, dir_next;
    logic [TIME_BITS-1:0]     dividend_reg, dividend_next;
    logic [FIELD_BITS-1:0]    addr_reg, addr_next;
    logic                     down_reg, down_next;
    logic                     issue_reg, issue_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic                     rd_first_reg, rd_first_next;
    logic                     rd_end_reg, rd_end_next;
    logic [FIELD_BITS-1:0]    rd_frame_reg, rd_frame_next;
    logic [TOTAL_BITS-1:0]    total_reg, total_next;
    logic [DURATION_BITS-1:0] dfirst_reg, dfirst_next;
    logic [DURATION_BITS-1:0] dlast_reg, dlast_next;
    logic [TOTAL_BITS:0]      rem_reg, rem_next;
    logic [STEP_BITS-1:0]     step_reg, step_next;
    logic [FIELD_BITS-1:0]    frame_reg, frame_next;
    logic                     zero_reg, zero_next;
    logic                     result_valid_reg, result_valid_next;
    tfsl_out_t                result_reg, result_next;

    logic                     accept;
    logic                     ram_we;
    logic [DURATION_BITS-1:0] ram_rdata;
    logic [TOTAL_BITS:0]      shifted;
    logic [TOTAL_BITS:0]      dur_ext;
    logic [FIELD_BITS-1:0]    walk_addr;
    logic                     walk_down;

    assign accept     = item_valid && item_ready;
    assign item_ready = (state_reg == S_IDLE);
    assign ram_we     = accept && (item.operation == OP_LOAD);

    tfsl_ram #(
        .WIDTH (DURATION_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (FRAME_BITS'(item.table_index)),
        .wdata (DURATION_BITS'(item.frame_duration)),
        .raddr (FRAME_BITS'(addr_reg)),
        .rdata (ram_rdata)
    );

    assign shifted = {rem_reg[TOTAL_BITS-1:0], dividend_reg[TIME_BITS-1]};
    assign dur_ext = {{(TOTAL_BITS + 1 - DURATION_BITS){1'b0}}, ram_rdata};

    always_comb
    begin
        walk_addr = first_reg;
        walk_down = 1'b0;
        if (dir_reg == DIR_REVERSE)
        begin
            walk_addr = last_reg;
            walk_down = 1'b1;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        first_next        = first_reg;
        last_next         = last_reg;
        dir_next          = dir_reg;
        dividend_next     = dividend_reg;
        addr_next         = addr_reg;
        down_next         = down_reg;
        issue_next        = 1'b0;
        rd_valid_next     = 1'b0;
        rd_first_next     = 1'b0;
        rd_end_next       = 1'b0;
        rd_frame_next     = addr_reg;
        total_next        = total_reg;
        dfirst_next       = dfirst_reg;
        dlast_next        = dlast_reg;
        rem_next          = rem_reg;
        step_next         = step_reg;
        frame_next        = frame_reg;
        zero_next         = zero_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.operation == OP_QUERY))
                begin
                    first_next    = item.first_frame;
                    last_next     = item.last_frame;
                    dir_next      = item.play_direction;
                    dividend_next = item.query_time;
                    addr_next     = item.first_frame;
                    total_next    = '0;
                    frame_next    = item.first_frame;
                    zero_next     = 1'b0;
                    if (item.last_frame < item.first_frame)
                    begin
                        zero_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        issue_next = 1'b1;
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                if (issue_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_first_next = (addr_reg == first_reg);
                    rd_end_next   = (addr_reg == last_reg);
                    issue_next    = (addr_reg != last_reg);
                    addr_next     = addr_reg + 1'b1;
                end
                if (rd_valid_reg)
                begin
                    total_next = total_reg + TOTAL_BITS'(ram_rdata);
                    if (rd_first_reg)
                    begin
                        dfirst_next = ram_rdata;
                    end
                    if (rd_end_reg)
                    begin
                        dlast_next = ram_rdata;
                        state_next = S_FIX;
                    end
                end
            end
            S_FIX:
            begin
                if (dir_reg == DIR_PINGPONG)
                begin
                    total_next = (total_reg << 1) - TOTAL_BITS'(dfirst_reg)
                                 - TOTAL_BITS'(dlast_reg);
                end
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (total_reg == '0)
                begin
                    zero_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (shifted >= {1'b0, total_reg})
                begin
                    rem_next = shifted - {1'b0, total_reg};
                end
                else
                begin
                    rem_next = shifted;
                end
                dividend_next = dividend_reg << 1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(TIME_BITS - 1))
                begin
                    addr_next  = walk_addr;
                    down_next  = walk_down;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                rd_valid_next = 1'b1;
                if ((dir_reg == DIR_PINGPONG) && !down_reg && (addr_reg == last_reg))
                begin
                    down_next = 1'b1;
                    addr_next = last_reg - 1'b1;
                end
                else if (down_reg)
                begin
                    addr_next = addr_reg - 1'b1;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
                if (rd_valid_reg)
                begin
                    if (rem_reg < dur_ext)
                    begin
                        frame_next    = rd_frame_reg;
                        rd_valid_next = 1'b0;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        rem_next = rem_reg - dur_ext;
                    end
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next        = 1'b1;
                    result_next.frame_number = frame_reg;
                    result_next.zero_length  = zero_reg;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            issue_reg        <= 1'b0;
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            issue_reg        <= issue_next;
            rd_valid_reg     <= rd_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg    <= first_next;
        last_reg     <= last_next;
        dir_reg      <= dir_next;
        dividend_reg <= dividend_next;
        addr_reg     <= addr_next;
        down_reg     <= down_next;
        rd_first_reg <= rd_first_next;
        rd_end_reg   <= rd_end_next;
        rd_frame_reg <= rd_frame_next;
        total_reg    <= total_next;
        dfirst_reg   <= dfirst_next;
        dlast_reg    <= dlast_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        frame_reg    <= frame_next;
        zero_reg     <= zero_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: tb/sv/timed_frame_sequence_lookup_test.sv
`timescale 1ns / 100ps
// Self-checking test of timed_frame_sequence_lookup: loads and frame queries go in,
// looked-up frames are predicted in the bench and compared as they come out.
// Depends on tfsl_pkg and the timed_frame_sequence_lookup RTL.
module timed_frame_sequence_lookup_test;
    import tfsl_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam longint TIMEOUT_CYCLES = 2_000_000;
    localparam int PHASE_ITEMS = 80;
    localparam int DRAIN_CYCLES = 600;

    logic clk;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    tfsl_in_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    tfsl_out_t result;

    tfsl_in_t queued_items[$];
    tfsl_out_t expected_lookups[$];
    logic [DURATION_BITS-1:0] frame_durations[MAX_FRAMES];
    logic [MAX_FRAMES-1:0] gen_loaded = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int phase_items = 0;
    int mismatches = 0;
    int loads_done = 0;
    int queries_checked = 0;
    int zero_totals = 0;

    timed_frame_sequence_lookup dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    function automatic tfsl_out_t lookup_frame(tfsl_in_t q);
        longint unsigned total;
        longint unsigned t;
        longint unsigned d;
        int lo;
        int hi;
        int f;
        tfsl_out_t r;
        lo = int'(q.first_frame);
        hi = int'(q.last_frame);
        r.frame_number = q.first_frame;
        r.zero_length = 1'b0;
        total = 0;
        if (hi >= lo)
        begin
            for (f = lo; f <= hi; f++)
                total += frame_durations[f];
            if (q.play_direction == DIR_PINGPONG)
                total = 2 * total - frame_durations[lo] - frame_durations[hi];
        end
        if (total == 0)
        begin
            r.zero_length = 1'b1;
            return r;
        end
        t = q.query_time % total;
        if (q.play_direction == DIR_REVERSE)
        begin
            for (f = hi; f >= lo; f--)
            begin
                d = frame_durations[f];
                if (t < d)
                begin
                    r.frame_number = FIELD_BITS'(f);
                    return r;
                end
                t -= d;
            end
            return r;
        end
        for (f = lo; f <= hi; f++)
        begin
            d = frame_durations[f];
            if (t < d)
            begin
                r.frame_number = FIELD_BITS'(f);
                return r;
            end
            t -= d;
        end
        // return leg of ping-pong skips both end frames
        if (q.play_direction == DIR_PINGPONG)
        begin
            for (f = hi - 1; f > lo; f--)
            begin
                d = frame_durations[f];
                if (t < d)
                begin
                    r.frame_number = FIELD_BITS'(f);
                    return r;
                end
                t -= d;
            end
        end
        return r;
    endfunction

    function automatic tfsl_in_t make_load(int idx, logic [15:0] dur);
        tfsl_in_t x;
        x.operation = OP_LOAD;
        x.table_index = FIELD_BITS'(idx);
        x.frame_duration = dur;
        x.first_frame = FIELD_BITS'($urandom);
        x.last_frame = FIELD_BITS'($urandom);
        x.play_direction = 2'($urandom);
        x.query_time = $urandom;
        return x;
    endfunction

    function automatic tfsl_in_t make_query(int first, int last, logic [1:0] dir,
                                            logic [31:0] t);
        tfsl_in_t x;
        x.operation = OP_QUERY;
        x.table_index = FIELD_BITS'($urandom);
        x.frame_duration = 16'($urandom);
        x.first_frame = FIELD_BITS'(first);
        x.last_frame = FIELD_BITS'(last);
        x.play_direction = dir;
        x.query_time = t;
        return x;
    endfunction

    function automatic logic [15:0] rand_duration();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(1, 16));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_time();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 2000);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 100);
            default: return $urandom;
        endcase
    endfunction

    // Stay inside one contiguous run of loaded entries; reversed ranges read nothing.
    function automatic tfsl_in_t rand_query();
        int anchor;
        int lo;
        int hi;
        int first;
        int span;
        int last;
        if ($urandom_range(0, 9) == 0)
        begin
            first = $urandom_range(1, MAX_FRAMES - 1);
            return make_query(first, $urandom_range(0, first - 1), 2'($urandom),
                              rand_time());
        end
        do
            anchor = $urandom_range(0, MAX_FRAMES - 1);
        while (!gen_loaded[anchor]);
        lo = anchor;
        hi = anchor;
        while (lo > 0 && gen_loaded[lo - 1])
            lo--;
        while (hi < MAX_FRAMES - 1 && gen_loaded[hi + 1])
            hi++;
        first = $urandom_range(lo, hi);
        span = ($urandom_range(0, 15) == 0) ? MAX_FRAMES : 8;
        last = $urandom_range(first, (first + span - 1 < hi) ? first + span - 1 : hi);
        return make_query(first, last, 2'($urandom), rand_time());
    endfunction

    task automatic push_item(tfsl_in_t x);
        queued_items.push_back(x);
        phase_items++;
        if (x.operation == OP_LOAD)
            gen_loaded[x.table_index] = 1'b1;
    endtask

    task automatic queue_directed();
        push_item(make_load(0, 16'hFFFF));
        push_item(make_load(1, 16'h0000));
        push_item(make_load(2, 16'd1));
        push_item(make_load(3, 16'd7));
        push_item(make_load(255, 16'd300));
        push_item(make_load(254, 16'd0));
        push_item(make_query(0, 0, DIR_FORWARD, 32'd0));
        push_item(make_query(0, 3, DIR_FORWARD, 32'hFFFF_FFFF));
        push_item(make_query(0, 3, DIR_REVERSE, 32'hFFFF_FFFF));
        push_item(make_query(0, 3, DIR_PINGPONG, 32'h0001_0005));
        push_item(make_query(0, 3, 2'd3, 32'd65540));
        push_item(make_query(1, 1, DIR_FORWARD, 32'd9));
        push_item(make_query(2, 2, DIR_PINGPONG, 32'd3));
        push_item(make_query(255, 255, DIR_FORWARD, 32'd299));
        push_item(make_query(254, 255, DIR_REVERSE, 32'd5));
        push_item(make_query(254, 255, DIR_PINGPONG, 32'd123));
        push_item(make_query(255, 0, DIR_FORWARD, 32'd17));
        push_item(make_query(200, 10, DIR_PINGPONG, 32'hFFFF_FFFF));
        push_item(make_query(0, 2, DIR_PINGPONG, 32'd0));
        push_item(make_query(1, 2, DIR_REVERSE, 32'd0));
        push_item(make_query(1, 3, DIR_PINGPONG, 32'd8));
    endtask

    task automatic queue_full_table();
        int i;
        for (i = 0; i < MAX_FRAMES; i++)
            push_item(make_load(i, rand_duration()));
        for (i = 0; i < 4; i++)
            push_item(make_query(0, MAX_FRAMES - 1, 2'(i), rand_time()));
    endtask

    // Load a block of entries, then queue queries over the loaded entries.
    task automatic queue_burst();
        int span;
        int start;
        int k;
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
        start = $urandom_range(0, MAX_FRAMES - span);
        for (k = 0; k < span; k++)
            if (!gen_loaded[start + k] || $urandom_range(0, 2) == 0)
                push_item(make_load(start + k, rand_duration()));
        repeat ($urandom_range(1, 6))
            push_item(rand_query());
    endtask

    task automatic wait_drained();
        while (queued_items.size() != 0 || item_valid || expected_lookups.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, bit fill_table);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        phase_items = 0;
        if (fill_table)
            queue_full_table();
        while (phase_items < PHASE_ITEMS)
            queue_burst();
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else if (!item_valid || item_ready)
        begin
            if (item_valid)
            begin
                if (item.operation == OP_LOAD)
                begin
                    frame_durations[item.table_index] = item.frame_duration;
                    loads_done++;
                end
                else
                    expected_lookups.push_back(lookup_frame(item));
            end
            if (queued_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                item <= queued_items.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        tfsl_out_t want;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_lookups.size() == 0)
                begin
                    $display("%0t: unexpected transaction, frame %0d zero_length %0b",
                             $time, result.frame_number, result.zero_length);
                    mismatches++;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    queries_checked++;
                    if (want.zero_length)
                        zero_totals++;
                    if (result.frame_number !== want.frame_number)
                    begin
                        $display("%0t: frame_number expected %0d actual %0d",
                                 $time, want.frame_number, result.frame_number);
                        mismatches++;
                    end
                    if (result.zero_length !== want.zero_length)
                    begin
                        $display("%0t: zero_length expected %0b actual %0b",
                                 $time, want.zero_length, result.zero_length);
                        mismatches++;
                    end
                end
            end
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("%0t: timeout", $time);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        queue_directed();
        wait_drained();
        run_phase(0, 0, 1'b0);
        run_phase(49, 0, 1'b1);
        run_phase(0, 49, 1'b0);
        run_phase(14, 14, 1'b0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Covered %0d loads and %0d queries (%0d with zero total)",
                 loads_done, queries_checked, zero_totals);
        $display("over all play directions, full-table ranges and four pacing phases.");
        if (mismatches == 0 && expected_lookups.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
